[hw/rtl/tdq_pkg.sv]
// tdq_pkg: shared types and constants of the timed display queue
// no dependencies; used by timed_display_queue
`timescale 1ns / 1ps

package tdq_pkg;

    // fixed widths of the transaction fields
    localparam int unsigned DATA_W  = 32;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned COUNT_W = 4;

    // command codes
    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // configuration register indexes
    localparam logic REG_DISPLAY_TIME     = 1'b0;
    localparam logic REG_DISPLAY_TIME_NAV = 1'b1;

    // configuration reset values
    localparam logic [TIME_W-1:0] DISPLAY_TIME_RST     = 32'd5000;
    localparam logic [TIME_W-1:0] DISPLAY_TIME_NAV_RST = 32'd3000;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_SHIFT_RD,
        ST_SHIFT_MV,
        ST_FILL,
        ST_POST,
        ST_READ
    } t_state;

endpackage

[hw/rtl/timed_display_queue.sv]
// timed_display_queue: top level, sequencer, timer compare and result registers
// depends on tdq_pkg and tdq_ram
`timescale 1ns / 1ps
//
// Usage
//   A transaction is taken at a rising edge with start high and busy low. cmd selects
//   add (append payload, show it, restart the timer at now) or tick (compare now minus
//   the start time with display_time or display_time_nav and retire the shown entry
//   on expiry). Every transaction gives exactly one result, shown for one cycle with
//   o_strobe high; the receiver cannot stall, so results are never held back.
//   The sequencer runs EVAL first. An add goes on to FILL; on a full queue it first
//   drops the oldest entry with a shift (SHIFT_RD, then SHIFT_MV for DEPTH-1 moves).
//   A tick ends in EVAL on an empty queue and reads the shown entry in READ when not
//   expired; on expiry at index k it shifts the entries above k down (SHIFT_RD, then
//   SHIFT_MV for count-1-k moves, when there are any), then runs POST, and READ
//   unless the queue is left empty.
//   busy stays high until the strobe cycle, in which the next transaction may be taken;
//   no new transaction is taken before the last one gives its result. Entries move
//   one a cycle through the single write port and single read port of the RAM.
//   Configuration writes (i_cfg_we, i_cfg_idx, i_cfg_data) are taken at once and
//   belong to idle periods. Reset (synchronous, active low) empties the queue, clears
//   the start time and loads the timeouts with 5000 and 3000.
//
module timed_display_queue #(
    parameter int unsigned DEPTH         = 8,
    parameter int unsigned PAYLOAD_WIDTH = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_idx,
    input  logic [tdq_pkg::TIME_W-1:0]  i_cfg_data,
    // command
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_cmd,
    input  logic [tdq_pkg::DATA_W-1:0]  i_payload,
    input  logic [tdq_pkg::TIME_W-1:0]  i_now,
    input  logic                        i_nav_active,
    // result
    output logic                        o_strobe,
    output logic [tdq_pkg::COUNT_W-1:0] o_queue_count,
    output logic [tdq_pkg::DATA_W-1:0]  o_shown_payload,
    output logic                        o_showing,
    output logic                        o_expired,
    output logic                        o_dropped
);

    import tdq_pkg::*;

    localparam int unsigned IW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned SW = (PAYLOAD_WIDTH < DATA_W) ? PAYLOAD_WIDTH : DATA_W;

    t_state r_state, n_state;

    logic [TIME_W-1:0] r_display_time, r_display_time_nav;
    logic [CW-1:0]     r_count;
    logic [IW-1:0]     r_cur;
    logic [TIME_W-1:0] r_start_time;

    // latched transaction
    logic              r_cmd;
    logic [SW-1:0]     r_payload;
    logic [TIME_W-1:0] r_now;
    logic [TIME_W-1:0] r_timeout;
    logic              r_exp;
    logic              r_drop;
    logic [IW-1:0]     r_ptr;
    logic [IW-1:0]     r_wptr;

    // entry RAM controls
    logic          ram_we;
    logic [IW-1:0] ram_waddr;
    logic [SW-1:0] ram_wdata;
    logic [IW-1:0] ram_raddr;
    logic [SW-1:0] ram_rdata;

    logic              accept;
    logic [TIME_W-1:0] elapsed;
    logic              elapsed_hit;
    logic              full;
    logic [CW-1:0]     cur_next;
    logic [CW-1:0]     ptr_next2;
    logic              shift_last;
    logic [CW-1:0]     count_dec;
    logic              timeout_nz;
    logic [CW+COUNT_W-1:0] count_ext;
    logic [SW+DATA_W-1:0]  rdata_ext;
    logic [SW+DATA_W-1:0]  payload_ext;

    assign accept      = start && !busy;
    assign busy        = (r_state != ST_IDLE);
    assign elapsed     = r_now - r_start_time;
    assign elapsed_hit = (elapsed >= r_timeout);
    assign full        = (r_count == CW'(DEPTH));
    assign cur_next    = CW'(r_cur) + CW'(1);
    assign ptr_next2   = CW'(r_ptr) + CW'(2);
    assign shift_last  = (ptr_next2 >= r_count);
    assign count_dec   = r_count - CW'(1);
    assign timeout_nz  = (r_timeout != '0);
    assign rdata_ext   = {{DATA_W{1'b0}}, ram_rdata};
    assign payload_ext = {{DATA_W{1'b0}}, r_payload};

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_display_time     <= DISPLAY_TIME_RST;
            r_display_time_nav <= DISPLAY_TIME_NAV_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_DISPLAY_TIME:     r_display_time     <= i_cfg_data;
                REG_DISPLAY_TIME_NAV: r_display_time_nav <= i_cfg_data;
                default:              ;
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) n_state = ST_EVAL;
            end
            ST_EVAL: begin
                if (r_cmd == CMD_ADD) begin
                    n_state = full ? ST_SHIFT_RD : ST_FILL;
                end else if (r_count == '0) begin
                    n_state = ST_IDLE;
                end else if (elapsed_hit) begin
                    n_state = (cur_next < r_count) ? ST_SHIFT_RD : ST_POST;
                end else begin
                    n_state = ST_READ;
                end
            end
            ST_SHIFT_RD: n_state = ST_SHIFT_MV;
            ST_SHIFT_MV: begin
                if (shift_last) n_state = (r_cmd == CMD_ADD) ? ST_FILL : ST_POST;
            end
            ST_FILL:     n_state = ST_IDLE;
            ST_POST:     n_state = (count_dec != '0) ? ST_READ : ST_IDLE;
            ST_READ:     n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    // entry RAM port control
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_ptr;
        ram_wdata = ram_rdata;
        ram_raddr = r_cur;
        unique case (r_state)
            ST_EVAL:     ram_raddr = r_cur;
            ST_SHIFT_RD: ram_raddr = IW'(CW'(r_ptr) + CW'(1));
            ST_SHIFT_MV: begin
                ram_we    = 1'b1;
                ram_raddr = shift_last ? '0 : ptr_next2[IW-1:0];
            end
            ST_FILL: begin
                ram_we    = 1'b1;
                ram_waddr = r_wptr;
                ram_wdata = r_payload;
            end
            ST_POST:     ram_raddr = '0;
            ST_IDLE, ST_READ: ram_raddr = r_cur;
            default:     ram_raddr = r_cur;
        endcase
    end

    tdq_ram #(
        .WIDTH (SW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // state and queue control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_count      <= '0;
            r_cur        <= '0;
            r_start_time <= '0;
            o_strobe     <= 1'b0;
        end else begin
            r_state  <= n_state;
            o_strobe <= 1'b0;
            unique case (r_state)
                ST_EVAL: begin
                    if (r_cmd == CMD_TICK && r_count == '0) o_strobe <= 1'b1;
                end
                ST_FILL: begin
                    if (!r_drop) r_count <= r_count + CW'(1);
                    r_cur        <= r_wptr;
                    r_start_time <= r_now;
                    o_strobe     <= 1'b1;
                end
                ST_POST: begin
                    r_count <= count_dec;
                    r_cur   <= '0;
                    if (count_dec != '0) begin
                        r_start_time <= r_now;
                    end else begin
                        o_strobe <= 1'b1;
                    end
                end
                ST_READ: o_strobe <= 1'b1;
                ST_IDLE, ST_SHIFT_RD, ST_SHIFT_MV: ;
                default: ;
            endcase
        end
    end

    // transaction capture, move pointer and result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd     <= i_cmd;
            r_payload <= i_payload[SW-1:0];
            r_now     <= i_now;
            r_timeout <= i_nav_active ? r_display_time_nav : r_display_time;
        end
        unique case (r_state)
            ST_EVAL: begin
                r_exp  <= (r_cmd == CMD_TICK) && elapsed_hit;
                r_drop <= (r_cmd == CMD_ADD) && full;
                r_ptr  <= (r_cmd == CMD_ADD) ? '0 : r_cur;
                r_wptr <= full ? IW'(DEPTH - 1) : r_count[IW-1:0];
                if (r_cmd == CMD_TICK && r_count == '0) begin
                    o_queue_count   <= '0;
                    o_shown_payload <= '0;
                    o_showing       <= 1'b0;
                    o_expired       <= 1'b0;
                    o_dropped       <= 1'b0;
                end
            end
            ST_SHIFT_MV: r_ptr <= r_ptr + IW'(1);
            ST_FILL: begin
                o_queue_count   <= r_drop ? count_ext[COUNT_W-1:0]
                                          : COUNT_W'(r_count + CW'(1));
                o_shown_payload <= payload_ext[DATA_W-1:0];
                o_showing       <= timeout_nz;
                o_expired       <= 1'b0;
                o_dropped       <= r_drop;
            end
            ST_POST: begin
                if (count_dec == '0) begin
                    o_queue_count   <= '0;
                    o_shown_payload <= '0;
                    o_showing       <= 1'b0;
                    o_expired       <= 1'b1;
                    o_dropped       <= 1'b0;
                end
            end
            ST_READ: begin
                o_queue_count   <= count_ext[COUNT_W-1:0];
                o_shown_payload <= rdata_ext[DATA_W-1:0];
                o_showing       <= r_exp ? timeout_nz : 1'b1;
                o_expired       <= r_exp;
                o_dropped       <= 1'b0;
            end
            ST_IDLE, ST_SHIFT_RD: ;
            default: ;
        endcase
    end

    assign count_ext = {{COUNT_W{1'b0}}, r_count};

    // checks on sequencer and queue bookkeeping
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result strobe while a transaction is still running");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("accepted transaction did not raise busy");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count above depth");

    a_cur_in_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && r_count != '0) |-> (CW'(r_cur) < r_count))
        else $error("shown index outside the queue");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !(o_expired && o_dropped))
        else $error("expired and dropped in one result");

endmodule

[hw/rtl/tdq_ram.sv]
// tdq_ram: generic single-write, single-read RAM with registered read data
// no dependencies
`timescale 1ns / 1ps

module tdq_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
